// ----- sv/von_mises_stress_defines.svh -----
// Assertion helpers, all clocked on clk_i and disabled while rst_ni is low.
`ifndef VON_MISES_STRESS_DEFINES_SVH
`define VON_MISES_STRESS_DEFINES_SVH

`ifndef SYNTHESIS

`define VMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vms assertion failed");

`define VMS_ASSERT_IMP(lbl, ante, cons) \
  `VMS_ASSERT(lbl, (ante) |-> (cons))

`define VMS_ASSERT_NXT(lbl, ante, cons) \
  `VMS_ASSERT(lbl, (ante) |=> (cons))

`else

`define VMS_ASSERT(lbl, prop)
`define VMS_ASSERT_IMP(lbl, ante, cons)
`define VMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- sv/vms_pkg.sv -----
`default_nettype none

package vms_pkg;

  localparam logic [1:0] DIM_INVALID = 2'd0;
  localparam logic [1:0] DIM_1D      = 2'd1;
  localparam logic [1:0] DIM_2D      = 2'd2;
  localparam logic [1:0] DIM_3D      = 2'd3;
  localparam logic [1:0] DIM_RESET   = DIM_3D;

  localparam int MODE_W = 2;

  // what the back end does with a word
  typedef enum logic [MODE_W-1:0] {
    MODE_ERR  = 2'd0,
    MODE_PASS = 2'd1,
    MODE_ROOT = 2'd2
  } mode_e;

  typedef struct packed {
    logic  valid;
    mode_e mode;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- sv/vms_front.sv -----
`default_nettype none

module vms_front #(
  parameter int W = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [1:0]             tensor_dim_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [W-1:0]    s_xx_i,
  input  wire logic signed [W-1:0]    s_yy_i,
  input  wire logic signed [W-1:0]    s_zz_i,
  input  wire logic signed [W-1:0]    s_xy_i,
  input  wire logic signed [W-1:0]    s_xz_i,
  input  wire logic signed [W-1:0]    s_yz_i,
  input  wire logic                   full_i,
  output logic                        push_o,
  output logic [vms_pkg::MODE_W+W+2*W+1:0] word_o
);

  localparam int PW = 2 * W;
  localparam int QW = 2 * W + 2;
  localparam int SW = 2 * W + 4;

  vms_pkg::ctrl_t c1_q, c2_q, c3_q, c4_q;
  vms_pkg::mode_e mode_d;
  logic           zero_hi;
  logic           en;

  logic signed [W-1:0]  a1_q, b1_q, c1v_q, d1_q, e1_q, f1_q;
  logic signed [W-1:0]  a2_q, a3_q, a4_q;
  logic signed [PW-1:0] aa_q, bb_q, cc_q, ab_q, bc_q, ca_q, dd_q, ee_q, ff_q;
  logic signed [SW-1:0] pos_q, neg_q, shr_q;
  logic signed [SW-1:0] q_full;
  logic [QW-1:0]        q4_q;

  // whole front stalls only when its last word cannot enter the queue
  assign en         = !(c4_q.valid && full_i);
  assign in_ready_o = en;
  assign push_o     = c4_q.valid && !full_i;
  assign word_o     = {c4_q.mode, a4_q, q4_q};

  always_comb begin
    zero_hi = (tensor_dim_i == vms_pkg::DIM_2D);
    case (tensor_dim_i)
      vms_pkg::DIM_INVALID: mode_d = vms_pkg::MODE_ERR;
      vms_pkg::DIM_1D:      mode_d = vms_pkg::MODE_PASS;
      default:              mode_d = vms_pkg::MODE_ROOT;
    endcase
  end

  assign q_full = pos_q - neg_q + shr_q + (shr_q <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (en) begin
      c1_q.valid <= in_valid_i;
      c1_q.mode  <= mode_d;
      c2_q       <= c1_q;
      c3_q       <= c2_q;
      c4_q       <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // 2D: out-of-plane terms forced to zero so one form covers both
      a1_q  <= s_xx_i;
      b1_q  <= s_yy_i;
      c1v_q <= zero_hi ? '0 : s_zz_i;
      d1_q  <= s_xy_i;
      e1_q  <= zero_hi ? '0 : s_xz_i;
      f1_q  <= zero_hi ? '0 : s_yz_i;

      aa_q <= a1_q * a1_q;
      bb_q <= b1_q * b1_q;
      cc_q <= c1v_q * c1v_q;
      ab_q <= a1_q * b1_q;
      bc_q <= b1_q * c1v_q;
      ca_q <= c1v_q * a1_q;
      dd_q <= d1_q * d1_q;
      ee_q <= e1_q * e1_q;
      ff_q <= f1_q * f1_q;
      a2_q <= a1_q;

      pos_q <= SW'(aa_q) + SW'(bb_q) + SW'(cc_q);
      neg_q <= SW'(ab_q) + SW'(bc_q) + SW'(ca_q);
      shr_q <= SW'(dd_q) + SW'(ee_q) + SW'(ff_q);
      a3_q  <= a2_q;

      // form is positive semidefinite and below 2^QW
      q4_q <= q_full[QW-1:0];
      a4_q <= a3_q;
    end
  end

endmodule

`default_nettype wire

// ----- sv/vms_fifo.sv -----
`default_nettype none

`include "von_mises_stress_defines.svh"

module vms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `VMS_ASSERT(a_cnt_range, cnt_q <= FULL_CNT)
  `VMS_ASSERT_IMP(a_no_overflow, push_i, !full_o)
  `VMS_ASSERT_IMP(a_no_underflow, pop_i, !empty_o)

endmodule

`default_nettype wire

// ----- sv/vms_back.sv -----
`default_nettype none

`include "von_mises_stress_defines.svh"

module vms_back #(
  parameter int W = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire logic [vms_pkg::MODE_W+W+2*W+1:0] word_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [W+1:0]                equiv_stress_o,
  output logic                               dim_error_o
);

  localparam int QW = 2 * W + 2;
  localparam int RB = W + 1;
  localparam int OW = W + 2;
  localparam logic [OW-1:0] MOST_NEG = {1'b1, {(OW-1){1'b0}}};

  vms_pkg::ctrl_t      ctl_q  [RB];
  logic [QW-1:0]       rm_q   [RB];
  logic [RB-1:0]       root_q [RB];
  logic signed [W-1:0] a_q    [RB];

  logic                out_valid_q;
  logic [OW-1:0]       equiv_q;
  logic                err_q;
  vms_pkg::mode_e      omode_q;
  logic                en;

  // one stall for the whole square-root pipe, set by the output register
  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign equiv_stress_o = equiv_q;
  assign dim_error_o = err_q;

  // one root bit per stage, most significant first; rm holds q - root^2
  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int B = RB - 1 - k;

    vms_pkg::ctrl_t      ctl_in;
    logic [QW-1:0]       rm_in;
    logic [RB-1:0]       root_in;
    logic signed [W-1:0] a_in;
    logic [QW-1:0]       trial;
    logic                take;

    if (k == 0) begin : g_first
      assign ctl_in.valid = pop_o;
      assign ctl_in.mode  = vms_pkg::mode_e'(word_i[QW+W +: vms_pkg::MODE_W]);
      assign rm_in        = word_i[QW-1:0];
      assign root_in      = '0;
      assign a_in         = word_i[QW +: W];
    end else begin : g_next
      assign ctl_in  = ctl_q[k-1];
      assign rm_in   = rm_q[k-1];
      assign root_in = root_q[k-1];
      assign a_in    = a_q[k-1];
    end

    // (root + 2^B)^2 - root^2, lower root bits still zero
    assign trial = (QW'(root_in) << (B + 1)) | ({{(QW-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = (rm_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rm_q[k]   <= take ? rm_in - trial : rm_in;
        root_q[k] <= take ? (root_in | ({{(RB-1){1'b0}}, 1'b1} << B)) : root_in;
        a_q[k]    <= a_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_q[RB-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      omode_q <= ctl_q[RB-1].mode;
      case (ctl_q[RB-1].mode)
        vms_pkg::MODE_ERR: begin
          equiv_q <= MOST_NEG;
          err_q   <= 1'b1;
        end
        vms_pkg::MODE_PASS: begin
          equiv_q <= OW'(a_q[RB-1]);
          err_q   <= 1'b0;
        end
        default: begin
          equiv_q <= {1'b0, root_q[RB-1]};
          err_q   <= 1'b0;
        end
      endcase
    end
  end

  `VMS_ASSERT_IMP(a_err_value, out_valid_q && err_q, equiv_q == MOST_NEG)
  `VMS_ASSERT_IMP(a_root_nonneg, out_valid_q && omode_q == vms_pkg::MODE_ROOT, !equiv_q[OW-1])
  `VMS_ASSERT_NXT(a_stall_holds, !en && ctl_q[RB-1].valid, ctl_q[RB-1].valid)

endmodule

`default_nettype wire

// ----- sv/von_mises_stress.sv -----
// Pipeline: four front stages (register, multiply, partial sums, form), the queue
//   and one square-root stage per result bit, then the output register.
// Throughput: one tensor per cycle; a full queue or a stalled output holds the input side.
// Reset: rst_ni clears all valid state and the 4-word queue; tensor_dim resets to 3.
`default_nettype none

module von_mises_stress #(
  parameter int COMPONENT_WIDTH = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [1:0]                   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_xx_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_yy_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_zz_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_xy_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_xz_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] s_yz_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COMPONENT_WIDTH+1:0] equiv_stress_o,
  output logic                              dim_error_o
);

  localparam int W      = COMPONENT_WIDTH;
  localparam int WORD_W = vms_pkg::MODE_W + W + 2 * W + 2;
  localparam int QDEPTH = 4;

  logic [1:0]        tensor_dim_q;
  logic              push, full, pop, empty;
  logic [WORD_W-1:0] wword, rword;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tensor_dim_q <= vms_pkg::DIM_RESET;
    end else if (cfg_valid_i) begin
      tensor_dim_q <= cfg_data_i;
    end
  end

  vms_front #(
    .W(W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tensor_dim_i (tensor_dim_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .s_xx_i       (s_xx_i),
    .s_yy_i       (s_yy_i),
    .s_zz_i       (s_zz_i),
    .s_xy_i       (s_xy_i),
    .s_xz_i       (s_xz_i),
    .s_yz_i       (s_yz_i),
    .full_i       (full),
    .push_o       (push),
    .word_o       (wword)
  );

  vms_fifo #(
    .WIDTH(WORD_W),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wword),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rword),
    .empty_o (empty)
  );

  vms_back #(
    .W(W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .word_i         (rword),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .equiv_stress_o (equiv_stress_o),
    .dim_error_o    (dim_error_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CW    = 24;
  localparam int OUT_W = CW + 2;
  localparam int LAT   = CW + 7;

  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct {
    logic signed [OUT_W-1:0] stress;
    logic                    dim_error;
  } stress_word_t;

  // Holds the stress words still owed by the block, oldest first.
  class stress_scoreboard;
    logic [1:0]   dim;
    stress_word_t owed_q[$];
    int           errors;

    function new();
      dim    = vms_pkg::DIM_RESET;
      errors = 0;
    endfunction

    function void note_tensor(logic signed [CW-1:0] xx, yy, zz, xy, xz, yz);
      stress_word_t w;
      longint a, b, c, d, e, f, q, root, t;
      a = xx; b = yy; c = zz; d = xy; e = xz; f = yz;
      w.dim_error = 1'b0;
      case (dim)
        vms_pkg::DIM_INVALID: begin
          w.stress    = {1'b1, {(OUT_W-1){1'b0}}};
          w.dim_error = 1'b1;
        end
        vms_pkg::DIM_1D: begin
          w.stress = OUT_W'(xx);
        end
        default: begin
          q = a*a + b*b - a*b + 3*d*d;
          if (dim == vms_pkg::DIM_3D) q += c*c - b*c - c*a + 3*(e*e + f*f);
          // bitwise floor root, MSB first
          root = 0;
          for (int k = OUT_W - 2; k >= 0; k--) begin
            t = root | (longint'(1) << k);
            if (t*t <= q) root = t;
          end
          w.stress = root[OUT_W-1:0];
        end
      endcase
      owed_q.push_back(w);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] stress, logic err);
      stress_word_t w;
      if (owed_q.size() == 0) begin
        $error("unexpected stress word: equiv_stress %0d dim_error %0b", stress, err);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (stress !== w.stress) begin
        $error("equiv_stress: expected %0d, actual %0d", w.stress, stress);
        errors++;
      end
      if (err !== w.dim_error) begin
        $error("dim_error: expected %0b, actual %0b", w.dim_error, err);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [CW-1:0] s_xx_i, s_yy_i, s_zz_i, s_xy_i, s_xz_i, s_yz_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [OUT_W-1:0] equiv_stress_o;
  logic dim_error_o;

  stress_scoreboard sb = new();
  bit idle_on     = 1'b1;
  int hold_cycles = 0;

  von_mises_stress #(
    .COMPONENT_WIDTH(CW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .s_xx_i        (s_xx_i),
    .s_yy_i        (s_yy_i),
    .s_zz_i        (s_zz_i),
    .s_xy_i        (s_xy_i),
    .s_xz_i        (s_xz_i),
    .s_yz_i        (s_yz_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .equiv_stress_o(equiv_stress_o),
    .dim_error_o   (dim_error_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Values seen right after the edge are the ones the block sampled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.dim = cfg_data_i;
      if (in_valid_i && in_ready_o)
        sb.note_tensor(s_xx_i, s_yy_i, s_zz_i, s_xy_i, s_xz_i, s_yz_i);
      if (out_valid_o && out_ready_i) sb.check_result(equiv_stress_o, dim_error_o);
    end
  end

  // Output side: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [CW-1:0] rand_comp();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return CW'($urandom_range(0, 511) - 256);
      default: return w[CW-1:0];
    endcase
  endfunction

  task automatic send_tensor(logic signed [CW-1:0] xx, yy, zz, xy, xz, yz);
    in_valid_i <= 1'b1;
    s_xx_i <= xx; s_yy_i <= yy; s_zz_i <= zz;
    s_xy_i <= xy; s_xz_i <= xz; s_yz_i <= yz;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_tensor();
    logic signed [CW-1:0] h;
    if ($urandom_range(0, 9) == 0) begin
      // hydrostatic: deviatoric part is zero
      h = rand_comp();
      send_tensor(h, h, h, '0, '0, '0);
    end else begin
      send_tensor(rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  task automatic write_dim(logic [1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every owed word, then let the pipeline empty out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed_q.size() != 0);
    repeat (LAT + 8) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0] phase_dim [10];
    phase_dim = '{vms_pkg::DIM_2D, vms_pkg::DIM_1D, vms_pkg::DIM_3D,
                  vms_pkg::DIM_INVALID, vms_pkg::DIM_3D, vms_pkg::DIM_2D,
                  vms_pkg::DIM_1D, vms_pkg::DIM_3D, vms_pkg::DIM_2D,
                  vms_pkg::DIM_3D};

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    s_xx_i = '0; s_yy_i = '0; s_zz_i = '0;
    s_xy_i = '0; s_xz_i = '0; s_yz_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3D from the reset value of the register
    send_tensor('0, '0, '0, '0, '0, '0);
    send_tensor(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_tensor(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_tensor(CMAX, CMIN, '0, '0, '0, '0);
    send_tensor('0, '0, '0, CMIN, CMIN, CMIN);
    send_tensor(CMIN, CMAX, CMIN, CMIN, CMIN, CMIN);  // largest form
    send_tensor(24'sd3, '0, '0, '0, '0, '0);
    send_tensor(24'sd5, 24'sd5, 24'sd5, '0, '0, '0);
    send_tensor(-24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1);

    drain();
    write_dim(vms_pkg::DIM_2D);
    send_tensor(24'sd100, -24'sd50, CMIN, 24'sd7, CMAX, CMIN);
    send_tensor(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX);
    send_tensor(CMIN, CMAX, '0, CMIN, '0, '0);
    send_tensor(CMAX, CMAX, '0, CMAX, '0, '0);
    send_tensor('0, '0, CMAX, '0, CMIN, CMAX);

    drain();
    write_dim(vms_pkg::DIM_1D);
    send_tensor(CMIN, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_tensor(CMAX, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_tensor(-24'sd1, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    send_tensor('0, CMIN, CMAX, CMIN, CMAX, CMIN);

    drain();
    write_dim(vms_pkg::DIM_INVALID);
    send_tensor(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_tensor('0, '0, '0, '0, '0, '0);
    send_tensor(CMIN, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());

    for (int p = 0; p < 10; p++) begin
      drain();
      write_dim(phase_dim[p]);
      if (p == 9) idle_on = 1'b0;
      for (int i = 0; i < 55; i++) begin
        // long output hold-off so the queue fills and in_ready_o drops
        if (p == 4 && i == 6) hold_cycles = 150;
        send_random_tensor();
      end
    end
    drain();

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/vms_pkg.sv
sv/vms_front.sv
sv/vms_fifo.sv
sv/vms_back.sv
sv/von_mises_stress.sv
dv/tb.sv
